// ===== hdl/tfl_pkg.sv =====
package tfl_pkg;

   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_LF         = 8'h0A;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_HEADER     = 8'h3E;
   localparam logic [7:0] END_CHAR        = 8'h7F;
   localparam logic [7:0] VDP_REG         = 8'h07;
   localparam logic [7:0] ZERO_BYTE       = 8'h00;
   localparam logic [7:0] COLOUR_RESET    = 8'h17;
   localparam logic [7:0] MAX_LINES_RESET = 8'd148;

   localparam logic [5:0] LAST_CHAR_COLUMN = 6'd38;
   localparam logic [5:0] PAD_LAST_COLUMN  = 6'd39;
   localparam logic [5:0] TAIL_END_COLUMN  = 6'd38;
   localparam logic [5:0] TAIL_GAP_COLUMN  = 6'd39;
   localparam logic [5:0] TAIL_ZERO0_COLUMN = 6'd40;
   localparam logic [5:0] TAIL_ZERO1_COLUMN = 6'd41;
   localparam logic [5:0] TAIL_REG_COLUMN  = 6'd42;
   localparam logic [5:0] TAIL_LAST_COLUMN = 6'd43;

   typedef enum logic [1:0] {
      MODE_TEXT   = 2'd0,
      MODE_BREAK  = 2'd1,
      MODE_HEADER = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SEL_SPACE = 2'd0,
      SEL_CHAR  = 2'd1,
      SEL_TAIL  = 2'd2
   } byte_sel_type;

   typedef enum logic [1:0] {
      COL_HOLD = 2'd0,
      COL_INC  = 2'd1,
      COL_CLR  = 2'd2,
      COL_ONE  = 2'd3
   } col_op_type;

   typedef struct packed {
      logic         load;
      logic         decode;
      logic         emit;
      byte_sel_type byte_sel;
      logic         last;
      logic         done;
      col_op_type   col_op;
      logic         lines_inc;
      logic         finish;
   } cmd_type;

   typedef struct packed {
      logic finished;
      logic is_eof;
      logic newline;
      logic text_go;
      logic col_zero;
      logic col_last_char;
      logic col_pad_end;
      logic col_tail_end;
      logic limit_hit;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/tfl_datapath.sv =====
module tfl_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_tdata,   // text_byte
   input  logic                req_tuser,   // op
   input  logic                csr_tvalid,
   output logic                csr_tready,
   input  logic [7:0]          csr_tdata,   // max_line_count
   input  tfl_pkg::cmd_type    cmd,
   output tfl_pkg::status_type status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tlast,
   output logic                rsp_tuser    // text_done
);

   logic [7:0]        max_lines_ff, max_lines_in;
   tfl_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        colour_ff, colour_in;
   logic [5:0]        column_ff, column_in;
   logic [7:0]        lines_ff, lines_in;
   logic              first_ff, first_in;
   logic              finished_ff, finished_in;
   logic              op_ff, op_in;
   logic [7:0]        byte_ff, byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              newline;
   logic              is_hex;
   logic [3:0]        hex_val;
   logic              header_exit;
   tfl_pkg::mode_type eff_mode;
   logic [7:0]        tail_byte;
   logic [7:0]        emit_byte;
   logic              out_free;

   assign csr_tready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign newline    = (byte_ff == tfl_pkg::CHAR_LF) || (byte_ff == tfl_pkg::CHAR_CR);

   always_comb begin
      is_hex  = 1'b0;
      hex_val = byte_ff[3:0];
      if (byte_ff inside {[8'h30:8'h39]}) begin
         is_hex = 1'b1;
      end else if (byte_ff inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         is_hex  = 1'b1;
         hex_val = byte_ff[3:0] + 4'd9;
      end
   end

   assign header_exit = (mode_ff == tfl_pkg::MODE_HEADER) && first_ff
                        && (byte_ff != tfl_pkg::CHAR_HEADER);

   always_comb begin
      case (mode_ff)
         tfl_pkg::MODE_HEADER: begin
            eff_mode = header_exit ? tfl_pkg::MODE_TEXT : tfl_pkg::MODE_HEADER;
         end
         tfl_pkg::MODE_BREAK: begin
            eff_mode = tfl_pkg::MODE_TEXT;
         end
         tfl_pkg::MODE_TEXT: begin
            eff_mode = tfl_pkg::MODE_TEXT;
         end
         default: begin
            eff_mode = mode_ff;
         end
      endcase
   end

   always_comb begin
      case (column_ff)
         tfl_pkg::TAIL_END_COLUMN:   tail_byte = tfl_pkg::END_CHAR;
         tfl_pkg::TAIL_GAP_COLUMN:   tail_byte = tfl_pkg::CHAR_SPACE;
         tfl_pkg::TAIL_ZERO0_COLUMN: tail_byte = tfl_pkg::ZERO_BYTE;
         tfl_pkg::TAIL_ZERO1_COLUMN: tail_byte = tfl_pkg::ZERO_BYTE;
         tfl_pkg::TAIL_REG_COLUMN:   tail_byte = tfl_pkg::VDP_REG;
         tfl_pkg::TAIL_LAST_COLUMN:  tail_byte = colour_ff;
         default:                    tail_byte = tfl_pkg::CHAR_SPACE;
      endcase
   end

   always_comb begin
      case (cmd.byte_sel)
         tfl_pkg::SEL_CHAR: emit_byte = byte_ff;
         tfl_pkg::SEL_TAIL: emit_byte = tail_byte;
         default:           emit_byte = tfl_pkg::CHAR_SPACE;
      endcase
   end

   always_comb begin
      status.finished      = finished_ff;
      status.is_eof        = op_ff;
      status.newline       = newline;
      status.text_go       = !newline && (eff_mode == tfl_pkg::MODE_TEXT);
      status.col_zero      = (column_ff == 6'd0);
      status.col_last_char = (column_ff == tfl_pkg::LAST_CHAR_COLUMN);
      status.col_pad_end   = (column_ff == tfl_pkg::PAD_LAST_COLUMN);
      status.col_tail_end  = (column_ff == tfl_pkg::TAIL_LAST_COLUMN);
      status.limit_hit     = (lines_ff >= max_lines_ff);
      status.out_free      = out_free;
   end

   always_comb begin
      max_lines_in = max_lines_ff;
      mode_in      = mode_ff;
      colour_in    = colour_ff;
      column_in    = column_ff;
      lines_in     = lines_ff;
      first_in     = first_ff;
      finished_in  = finished_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      if (csr_tvalid) begin
         max_lines_in = csr_tdata;
      end
      if (cmd.load) begin
         op_in   = req_tuser;
         byte_in = req_tdata;
      end
      if (cmd.decode && !finished_ff && !op_ff) begin
         first_in = 1'b0;
         mode_in  = newline ? tfl_pkg::MODE_BREAK : eff_mode;
         if (!newline && (mode_ff == tfl_pkg::MODE_HEADER) && !header_exit && is_hex) begin
            colour_in = {colour_ff[3:0], hex_val};
         end
      end
      case (cmd.col_op)
         tfl_pkg::COL_INC: column_in = column_ff + 6'd1;
         tfl_pkg::COL_CLR: column_in = 6'd0;
         tfl_pkg::COL_ONE: column_in = 6'd1;
         default:          column_in = column_ff;
      endcase
      if (cmd.lines_inc) begin
         lines_in = lines_ff + 8'd1;
      end
      if (cmd.finish) begin
         finished_in = 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = cmd.last;
         rsp_done_in  = cmd.done;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lines_ff <= tfl_pkg::MAX_LINES_RESET;
         mode_ff      <= tfl_pkg::MODE_HEADER;
         colour_ff    <= tfl_pkg::COLOUR_RESET;
         column_ff    <= 6'd0;
         lines_ff     <= 8'd0;
         first_ff     <= 1'b1;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_lines_ff <= max_lines_in;
         mode_ff      <= mode_in;
         colour_ff    <= colour_in;
         column_ff    <= column_in;
         lines_ff     <= lines_in;
         first_ff     <= first_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("emit while output register held");

   column_in_range: assert property (@(posedge clock) disable iff (reset)
      column_ff <= tfl_pkg::TAIL_LAST_COLUMN)
      else $error("column out of range");

   silent_after_tail: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !cmd.emit)
      else $error("emit after tail");

   done_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.done) |=> (rsp_tvalid && rsp_tlast && rsp_tuser))
      else $error("closing colour byte not marked last");

endmodule

// ===== hdl/tfl_controller.sv =====
module tfl_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tfl_pkg::status_type status,
   output tfl_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_PAD    = 7'b0000100,
      ST_OPEN   = 7'b0001000,
      ST_CHAR   = 7'b0010000,
      ST_WRAP   = 7'b0100000,
      ST_TAIL   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd.load      = 1'b0;
      cmd.decode    = 1'b0;
      cmd.emit      = 1'b0;
      cmd.byte_sel  = tfl_pkg::SEL_SPACE;
      cmd.last      = 1'b0;
      cmd.done      = 1'b0;
      cmd.col_op    = tfl_pkg::COL_HOLD;
      cmd.lines_inc = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (status.finished) begin
               state_in = ST_IDLE;
            end else if (status.is_eof) begin
               state_in = ST_TAIL;
            end else if (status.newline) begin
               state_in = status.col_zero ? ST_IDLE : ST_PAD;
            end else if (status.text_go) begin
               state_in = status.col_zero ? ST_OPEN : ST_CHAR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.col_pad_end) begin
                  cmd.last   = 1'b1;
                  cmd.col_op = tfl_pkg::COL_CLR;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.col_op = tfl_pkg::COL_INC;
               end
            end
         end
         ST_OPEN: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.col_op = tfl_pkg::COL_ONE;
               if (status.limit_hit) begin
                  state_in = ST_TAIL;
               end else begin
                  cmd.lines_inc = 1'b1;
                  state_in      = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.byte_sel = tfl_pkg::SEL_CHAR;
               cmd.col_op   = tfl_pkg::COL_INC;
               cmd.last     = !status.col_last_char;
               state_in     = status.col_last_char ? ST_WRAP : ST_IDLE;
            end
         end
         ST_WRAP: begin
            if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.col_op = tfl_pkg::COL_CLR;
               state_in   = ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.byte_sel = tfl_pkg::SEL_TAIL;
               if (status.col_tail_end) begin
                  cmd.last   = 1'b1;
                  cmd.done   = 1'b1;
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.col_op = tfl_pkg::COL_INC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DECODE))
      else $error("load not followed by decode");

   last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> req_tready)
      else $error("last result not followed by idle");

   no_emit_in_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.emit)
      else $error("emit while accepting");

endmodule

// ===== hdl/text_to_fixed_width_lines_core.sv =====
// Rewrites a text byte stream as 40-byte display lines: a leading space, up to 38 text bytes,
// then a closing space on wrap or space padding on CR/LF, with an optional '>' header line whose
// hex digits set the colour byte; end of file or exceeding max_line_count emits the tail
// (spaces to column 38, 0x7F, space, 0x00, 0x00, 0x07, colour) and all later input is dropped.
// An input transaction is taken while idle and decoded in the next cycle, and then each result byte
// leaves through the single output register at one per cycle while rsp_tready is high, giving
// from 0 to 44 results per item; the next item is accepted on the cycle after the last result is
// loaded. csr_tready is always high; write it only when idle.
module text_to_fixed_width_lines_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] op
   input  logic       csr_tvalid,
   output logic       csr_tready,
   input  logic [7:0] csr_tdata,   // [7:0] max_line_count
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] text_done
);

   tfl_pkg::cmd_type    cmd;
   tfl_pkg::status_type status;

   tfl_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tfl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
